// File: hdl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg: shared constants of the tone sequencer
// Field widths, request codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int FUNC_W   = 1;
  localparam int IN_IDX_W = 10;
  localparam int NOTE_W   = 16;
  localparam int POS_W    = 10;
  localparam int TLEN_W   = 11;
  localparam int FREQ_W   = 21;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = FREQ_W;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TUNE_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_START  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FREQ    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_FREQ    = 2'd3;

  // register reset values
  localparam logic [TLEN_W-1:0]   TUNE_LENGTH_RST = 11'd1;
  localparam logic [IN_IDX_W-1:0] LOOP_START_RST  = 10'd0;
  localparam logic [FREQ_W-1:0]   MIN_FREQ_RST    = 21'd18;
  localparam logic [FREQ_W-1:0]   MAX_FREQ_RST    = 21'd596591;

  // divisor clamp values
  localparam logic [NOTE_W-1:0] DIV_SAT   = 16'hFFFF;
  localparam logic [NOTE_W-1:0] DIV_FLOOR = 16'd2;

endpackage

// File: hdl/tsd_if.sv
// ----------------------------------------------------------------------------
// tsd_if: request, result and configuration channels
// Valid/ready channels of the tone sequencer, each with source and sink views.
// ----------------------------------------------------------------------------
interface tsd_in_if import tsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [IN_IDX_W-1:0] entry_index;
  logic [NOTE_W-1:0]   note_freq;
  logic [NOTE_W-1:0]   note_ticks;

  modport source (output valid, func, entry_index, note_freq, note_ticks, input ready);
  modport sink   (input valid, func, entry_index, note_freq, note_ticks, output ready);
endinterface

interface tsd_out_if import tsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              spk_gate;
  logic [NOTE_W-1:0] divisor;
  logic              load_divisor;
  logic [POS_W-1:0]  position;

  modport source (output valid, spk_gate, divisor, load_divisor, position, input ready);
  modport sink   (input valid, spk_gate, divisor, load_divisor, position, output ready);
endinterface

interface tsd_cfg_if import tsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// File: hdl/tsd_div.sv
// ----------------------------------------------------------------------------
// tsd_div: restoring divider, one quotient bit per cycle
// Latches operands on start, pulses done after DVD_W steps.
// ----------------------------------------------------------------------------
module tsd_div #(
  parameter int DVD_W = 21,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;
  logic             fits;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] quo_nxt;

  // shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    fits    = ~diff[DVS_W+1];
    rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/tune_sequencer_tone_divider_core.sv
// ----------------------------------------------------------------------------
// tune_sequencer_tone_divider_core: note table player with tone divisor
// Write requests fill a note table; tick requests step playback and produce
// the speaker gate and the tone counter divisor CLOCK_FREQ / freq (clamped).
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  ---------------------------------------
//  cfg_ch    in   cfg_ch.valid/ready   addr (register index), wdata
//  in_ch     in   in_ch.valid/ready    func, entry_index, note_freq, note_ticks
//  out_ch    out  out_ch.valid/ready   spk_gate, divisor, load_divisor,
//                                      position
//
// Steps: a write request passes IDLE, WRITE and DONE; a tick that only counts
// down passes IDLE, CHECK and DONE, a tick that starts a rest or a clamped note
// also passes READ and NOTE, and a tick that needs a division then waits in TDIV
// on the restoring divider, which makes one quotient bit per cycle.
// When TABLE_DEPTH is below 1024 a write request first reduces its entry index,
// and a tick its loop start index, modulo the depth by compare and subtract, one
// shifted multiple of the depth per cycle.
// Reset: synchronous, active low; table contents stay undefined until written,
// so no clearing pass is run.
// Stalls: one result waits in the output register while the next request is
// taken; a request finishes only once that register is free.
//
module tune_sequencer_tone_divider_core import tsd_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int CLOCK_FREQ  = 1193182
) (
  input  logic clk,
  input  logic rst_n,
  tsd_cfg_if.sink   cfg_ch,
  tsd_in_if.sink    in_ch,
  tsd_out_if.source out_ch
);

  localparam int  IDX_W    = $clog2(TABLE_DEPTH);
  localparam int  CF_W     = $clog2(CLOCK_FREQ + 1);
  localparam int  DVD_W    = (CF_W > IN_IDX_W) ? CF_W : IN_IDX_W;
  localparam int  DVS_W    = NOTE_W;
  localparam int  CMP_W    = ((IDX_W + 1) > TLEN_W) ? (IDX_W + 1) : TLEN_W;
  localparam bit  NEED_MOD = (TABLE_DEPTH < (1 << IN_IDX_W));
  localparam int  MOD_W    = 2 * IN_IDX_W;
  localparam int  MCNT_W   = $clog2(IN_IDX_W + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_NOTE  = 3'd5;
  localparam logic [2:0] S_TDIV  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // note table: frequency in the upper half, duration in the lower half
  logic [2*NOTE_W-1:0] note_mem [TABLE_DEPTH];
  logic [2*NOTE_W-1:0] rd_data_r;
  logic                mem_we;
  logic                mem_re;
  logic [IDX_W-1:0]    rd_addr;

  // configuration registers
  logic [TLEN_W-1:0]   tune_length_r;
  logic [IN_IDX_W-1:0] loop_start_r;
  logic [FREQ_W-1:0]   min_freq_r;
  logic [FREQ_W-1:0]   max_freq_r;

  // sequencer and playback state
  logic [2:0]          state_r,       state_nxt;
  logic [FUNC_W-1:0]   func_r,        func_nxt;
  logic [NOTE_W-1:0]   freq_r,        freq_nxt;
  logic [NOTE_W-1:0]   ticks_r,       ticks_nxt;
  logic [IDX_W-1:0]    slot_r,        slot_nxt;
  logic [IDX_W-1:0]    loop_slot_r,   loop_slot_nxt;
  logic [IDX_W-1:0]    play_index_r,  play_index_nxt;
  logic [NOTE_W-1:0]   ticks_left_r,  ticks_left_nxt;
  logic                speaker_r,     speaker_nxt;
  logic [NOTE_W-1:0]   last_div_r,    last_div_nxt;
  logic                load_r,        load_nxt;

  // index reduction: value, shifted depth and step count
  logic [IN_IDX_W-1:0] mod_val_r,     mod_val_nxt;
  logic [MOD_W-1:0]    mod_sub_r,     mod_sub_nxt;
  logic [MCNT_W-1:0]   mod_cnt_r,     mod_cnt_nxt;
  logic [IN_IDX_W-1:0] mod_step;

  // output register
  logic                out_valid_r,   out_valid_nxt;
  logic                out_spk_r,     out_spk_nxt;
  logic [NOTE_W-1:0]   out_div_r,     out_div_nxt;
  logic                out_load_r,    out_load_nxt;
  logic [POS_W-1:0]    out_pos_r,     out_pos_nxt;

  // restoring divider
  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic                div_done;
  logic [DVD_W-1:0]    div_quo;

  logic                in_acc;
  logic [IDX_W-1:0]    cur_index;
  logic [IDX_W:0]      next_index;
  logic [NOTE_W-1:0]   rd_freq;
  logic [NOTE_W-1:0]   rd_ticks;

  tsd_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign rd_freq  = rd_data_r[2*NOTE_W-1:NOTE_W];
  assign rd_ticks = rd_data_r[NOTE_W-1:0];

  // wrap the position before a tick uses it
  assign cur_index  = (CMP_W'(play_index_r) >= CMP_W'(tune_length_r)) ? loop_slot_r
                                                                       : play_index_r;
  assign next_index = {1'b0, play_index_r} + (IDX_W + 1)'(1);

  assign rd_addr = cur_index;

  // drop one shifted multiple of the depth when it fits
  assign mod_step = (MOD_W'(mod_val_r) >= mod_sub_r) ?
                    (mod_val_r - mod_sub_r[IN_IDX_W-1:0]) : mod_val_r;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    freq_nxt       = freq_r;
    ticks_nxt      = ticks_r;
    slot_nxt       = slot_r;
    loop_slot_nxt  = loop_slot_r;
    play_index_nxt = play_index_r;
    ticks_left_nxt = ticks_left_r;
    speaker_nxt    = speaker_r;
    last_div_nxt   = last_div_r;
    load_nxt       = load_r;
    mod_val_nxt    = mod_val_r;
    mod_sub_nxt    = mod_sub_r;
    mod_cnt_nxt    = mod_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_spk_nxt    = out_spk_r;
    out_div_nxt    = out_div_r;
    out_load_nxt   = out_load_r;
    out_pos_nxt    = out_pos_r;
    div_start      = 1'b0;
    div_dvd        = '0;
    div_dvs        = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt      = in_ch.func;
          freq_nxt      = in_ch.note_freq;
          ticks_nxt     = in_ch.note_ticks;
          load_nxt      = 1'b0;
          slot_nxt      = IDX_W'(in_ch.entry_index);
          loop_slot_nxt = IDX_W'(loop_start_r);
          if (NEED_MOD) begin
            // reduce the table index modulo the depth, highest multiple first
            mod_val_nxt = (in_ch.func == FUNC_TICK) ? loop_start_r : in_ch.entry_index;
            mod_sub_nxt = MOD_W'(TABLE_DEPTH) << (IN_IDX_W - 1);
            mod_cnt_nxt = MCNT_W'(IN_IDX_W);
            state_nxt   = S_MOD;
          end else begin
            state_nxt = (in_ch.func == FUNC_TICK) ? S_CHECK : S_WRITE;
          end
        end
      end

      S_MOD: begin
        mod_val_nxt = mod_step;
        mod_sub_nxt = mod_sub_r >> 1;
        mod_cnt_nxt = mod_cnt_r - MCNT_W'(1);
        if (mod_cnt_r == MCNT_W'(1)) begin
          if (func_r == FUNC_TICK) begin
            loop_slot_nxt = IDX_W'(mod_step);
            state_nxt     = S_CHECK;
          end else begin
            slot_nxt  = IDX_W'(mod_step);
            state_nxt = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_CHECK: begin
        play_index_nxt = cur_index;
        if (ticks_left_r != '0) begin
          ticks_left_nxt = ticks_left_r - NOTE_W'(1);
          state_nxt      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        // table data lands in rd_data_r
        state_nxt = S_NOTE;
      end

      S_NOTE: begin
        // a zero duration counts as one tick
        ticks_left_nxt = (rd_ticks == '0) ? '0 : rd_ticks - NOTE_W'(1);
        if ((CMP_W'(next_index) >= CMP_W'(tune_length_r)) ||
            (next_index >= (IDX_W + 1)'(TABLE_DEPTH))) begin
          play_index_nxt = loop_slot_r;
        end else begin
          play_index_nxt = next_index[IDX_W-1:0];
        end
        if (rd_freq == '0) begin
          speaker_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          speaker_nxt = 1'b1;
          load_nxt    = 1'b1;
          if (FREQ_W'(rd_freq) <= min_freq_r) begin
            last_div_nxt = DIV_SAT;
            state_nxt    = S_DONE;
          end else if (FREQ_W'(rd_freq) > max_freq_r) begin
            last_div_nxt = DIV_FLOOR;
            state_nxt    = S_DONE;
          end else begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(CLOCK_FREQ);
            div_dvs   = rd_freq;
            state_nxt = S_TDIV;
          end
        end
      end

      S_TDIV: begin
        if (div_done) begin
          // saturate the quotient to the counter width
          last_div_nxt = (32'(div_quo) > 32'(DIV_SAT)) ? DIV_SAT : NOTE_W'(div_quo);
          state_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_spk_nxt   = speaker_r;
          out_div_nxt   = last_div_r;
          out_load_nxt  = load_r;
          out_pos_nxt   = POS_W'(play_index_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      play_index_r  <= '0;
      ticks_left_r  <= '0;
      speaker_r     <= 1'b1;
      last_div_r    <= '0;
      load_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      tune_length_r <= TUNE_LENGTH_RST;
      loop_start_r  <= LOOP_START_RST;
      min_freq_r    <= MIN_FREQ_RST;
      max_freq_r    <= MAX_FREQ_RST;
    end else begin
      state_r      <= state_nxt;
      play_index_r <= play_index_nxt;
      ticks_left_r <= ticks_left_nxt;
      speaker_r    <= speaker_nxt;
      last_div_r   <= last_div_nxt;
      load_r       <= load_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_TUNE_LENGTH: tune_length_r <= cfg_ch.wdata[TLEN_W-1:0];
          REG_LOOP_START:  loop_start_r  <= cfg_ch.wdata[IN_IDX_W-1:0];
          REG_MIN_FREQ:    min_freq_r    <= cfg_ch.wdata[FREQ_W-1:0];
          REG_MAX_FREQ:    max_freq_r    <= cfg_ch.wdata[FREQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    freq_r      <= freq_nxt;
    ticks_r     <= ticks_nxt;
    slot_r      <= slot_nxt;
    loop_slot_r <= loop_slot_nxt;
    mod_val_r   <= mod_val_nxt;
    mod_sub_r   <= mod_sub_nxt;
    mod_cnt_r   <= mod_cnt_nxt;
    out_spk_r   <= out_spk_nxt;
    out_div_r   <= out_div_nxt;
    out_load_r  <= out_load_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  // note table port: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[slot_r] <= {freq_r, ticks_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= note_mem[rd_addr];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.spk_gate     = out_spk_r;
  assign out_ch.divisor      = out_div_r;
  assign out_ch.load_divisor = out_load_r;
  assign out_ch.position     = out_pos_r;

endmodule
